>>> sv/multidim_array_address_generator_defines.svh
// ----------------------------------------------------------------------------
// Multidim array address generator: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef MULTIDIM_ARRAY_ADDRESS_GENERATOR_DEFINES_SVH
`define MULTIDIM_ARRAY_ADDRESS_GENERATOR_DEFINES_SVH

// Assertion sampled on the rising clock, switched off while reset is low
`define MAAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion sampled on the rising clock, also checked through reset
`define MAAG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/maag_pkg.sv
// ----------------------------------------------------------------------------
// Multidim array address generator package
// Beat types, command codes, descriptor layouts and back-end states.
// ----------------------------------------------------------------------------
package maag_pkg;

  localparam int unsigned DIMS_W = 4;
  localparam int unsigned AID_W  = 4;
  localparam int unsigned IDX_W  = 16;
  localparam int unsigned ADDR_W = 64;
  localparam logic [DIMS_W-1:0] CNT_SAT = 4'd15;

  // Input function codes
  typedef enum logic [1:0] {
    FUNC_HDR  = 2'd0,
    FUNC_BND  = 2'd1,
    FUNC_IDX  = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNDEF    = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_e;

  // Classified command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_BND,
    CMD_IDX
  } cmd_kind_e;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_ADR_LO,
    ST_ADR_HI,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]              func;
    logic [AID_W-1:0]        array_id;
    logic [DIMS_W-1:0]       dim_pos;
    logic [31:0]             base_addr;
    logic [15:0]             elem_size;
    logic [DIMS_W-1:0]       num_dims;
    logic signed [IDX_W-1:0] lower_bound;
    logic signed [IDX_W-1:0] upper_bound;
    logic signed [IDX_W-1:0] index_value;
    logic                    last_index;
  } in_item_t;

  typedef struct packed {
    logic signed [ADDR_W-1:0] address;
    logic [AID_W-1:0]         result_array;
    logic [1:0]               status;
  } out_item_t;

  // Command held in the queue between front and back
  typedef struct packed {
    cmd_kind_e kind;
    logic      id_ok;
    in_item_t  item;
  } cmd_t;

  // Descriptor table entry
  typedef struct packed {
    logic [31:0]       base;
    logic [15:0]       size;
    logic [DIMS_W-1:0] dims;
  } desc_t;

  // Bounds table entry
  typedef struct packed {
    logic [IDX_W-1:0] lower;
    logic [IDX_W-1:0] upper;
  } bnd_t;

endpackage

>>> sv/multidim_array_address_generator.sv
// Header and bounds beats are written to the tables as they leave the queue.
// Index beats pass the bounds memory read, two 32x32 partial products on the shared
// multiplier and the add; a final index then forms two element-size partial products
// and the address sum (skipped on error) and waits until the output register is free.
// A two-entry queue lets input beats arrive while the back end is busy.
// Reset clears the defined flags, access state, queue and output valid; no clearing pass.
// ----------------------------------------------------------------------------
// Multidim array address generator
// Row-major address calculation over a table of array descriptors.
// ----------------------------------------------------------------------------
module multidim_array_address_generator #(
  parameter int NUM_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  maag_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output maag_pkg::out_item_t out_item_o
);
  import maag_pkg::*;

  logic push, full, pop, empty;
  cmd_t cmd, head;

  // Classify incoming beats
  maag_front #(
    .NUM_ARRAYS(NUM_ARRAYS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .in_ready_o(in_ready_o),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  // Decouple front and back
  maag_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .head_o (head)
  );

  // Execute commands and produce results
  maag_back #(
    .NUM_ARRAYS(NUM_ARRAYS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

>>> sv/maag_front.sv
// ----------------------------------------------------------------------------
// Multidim array address generator: front end
// Accepts input beats, classifies them and drops those with no effect.
// ----------------------------------------------------------------------------
module maag_front #(
  parameter int NUM_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  logic              in_valid_i,
  input  maag_pkg::in_item_t in_item_i,
  output logic              in_ready_o,
  input  logic              full_i,
  output logic              push_o,
  output maag_pkg::cmd_t    cmd_o
);
  import maag_pkg::*;

  logic      id_ok;
  logic      pos_ok;
  logic      keep;
  cmd_kind_e kind;

  // Check the addressed table entry and dimension position
  assign id_ok  = 32'(in_item_i.array_id) < NUM_ARRAYS;
  assign pos_ok = (in_item_i.dim_pos != '0) && (32'(in_item_i.dim_pos) <= MAX_DIMS);

  // Classify the beat; drop no-op headers, bounds and unused codes
  always_comb begin
    kind = CMD_IDX;
    keep = 1'b0;
    unique case (func_e'(in_item_i.func))
      FUNC_HDR: begin
        kind = CMD_HDR;
        keep = id_ok;
      end
      FUNC_BND: begin
        kind = CMD_BND;
        keep = id_ok && pos_ok;
      end
      FUNC_IDX: begin
        kind = CMD_IDX;
        keep = 1'b1;
      end
      FUNC_NONE: begin
        kind = CMD_IDX;
        keep = 1'b0;
      end
    endcase
  end

  // Build the command, clamping the dimension count
  always_comb begin
    cmd_o       = '0;
    cmd_o.kind  = kind;
    cmd_o.id_ok = id_ok;
    cmd_o.item  = in_item_i;
    if (32'(in_item_i.num_dims) > MAX_DIMS) begin
      cmd_o.item.num_dims = DIMS_W'(MAX_DIMS);
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

>>> sv/maag_queue.sv
// ----------------------------------------------------------------------------
// Multidim array address generator: command queue
// Two-entry queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module maag_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  maag_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output maag_pkg::cmd_t head_o
);
  import maag_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = entry_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> sv/maag_back.sv
// ----------------------------------------------------------------------------
// Multidim array address generator: back end
// Descriptor tables, offset accumulation through a shared 32x32 multiplier,
// final address computation and the output register.
// ----------------------------------------------------------------------------
module maag_back #(
  parameter int NUM_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  maag_pkg::cmd_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output maag_pkg::out_item_t out_item_o
);
  import maag_pkg::*;

  localparam int ID_W   = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
  localparam int SLOTS  = NUM_ARRAYS * MAX_DIMS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  back_state_e state_q, state_d;

  // Tables
  desc_t                 desc_mem [NUM_ARRAYS];
  bnd_t                  bnd_mem  [SLOTS];
  logic [NUM_ARRAYS-1:0] defined_q;
  desc_t                 desc_rd_q;
  bnd_t                  bnd_rd_q;

  // Access state and datapath registers
  cmd_t              cur_q;
  logic              apply_q;
  logic [63:0]       acc_q;
  logic [DIMS_W-1:0] cnt_q;
  logic [63:0]       p_lo_q;
  logic [31:0]       p_hi_q;
  status_e           status_q, status_d;
  logic              out_valid_q;
  out_item_t         out_q;

  // Control from the output decoder
  logic hdr_we, bnd_we, rd_en;
  logic hi_sel, size_sel, plo_en, phi_en;
  logic acc_step, load;

  // Head decode
  logic [7:0]        hid_ext;
  logic [ID_W-1:0]   hid;
  logic              apply;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] rd_slot;

  assign hid_ext = {4'b0, head_i.item.array_id};
  assign hid     = hid_ext[ID_W-1:0];
  assign apply   = head_i.id_ok && (32'(cnt_q) < MAX_DIMS);
  assign wr_slot = SLOT_W'(32'(hid) * MAX_DIMS + 32'(head_i.item.dim_pos) - 1);
  assign rd_slot = apply ? SLOT_W'(32'(hid) * MAX_DIMS + 32'(cnt_q)) : '0;

  // Current item decode
  logic [7:0]      cid_ext;
  logic [ID_W-1:0] cid;
  assign cid_ext = {4'b0, cur_q.item.array_id};
  assign cid     = cid_ext[ID_W-1:0];

  // Extent, subscript difference and the shared multiplier
  logic [17:0] extent;
  logic [16:0] diff;
  logic [31:0] ext_lo;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] corr;
  logic [63:0] acc_d;
  logic [4:0]  total;
  logic [63:0] addr_sum;

  assign extent = {{2{bnd_rd_q.upper[15]}}, bnd_rd_q.upper}
                - {{2{bnd_rd_q.lower[15]}}, bnd_rd_q.lower} + 18'd1;
  assign diff   = {cur_q.item.index_value[15], cur_q.item.index_value}
                - {bnd_rd_q.lower[15], bnd_rd_q.lower};
  assign ext_lo = {{14{extent[17]}}, extent};
  assign mul_a  = hi_sel ? acc_q[63:32] : acc_q[31:0];
  assign mul_b  = size_sel ? {16'b0, desc_rd_q.size} : ext_lo;
  assign prod   = mul_a * mul_b;

  // High word of a negative extent contributes minus the low accumulator word
  assign corr  = extent[17] ? (32'd0 - acc_q[31:0]) : 32'd0;
  assign acc_d = p_lo_q + {p_hi_q + corr, 32'b0} + {{47{diff[16]}}, diff};

  assign total    = {1'b0, cnt_q} + 5'd1;
  assign addr_sum = {32'b0, desc_rd_q.base} + p_lo_q + {p_hi_q, 32'b0};

  // Judge the access on the array of its last item
  always_comb begin
    if (!cur_q.id_ok || !defined_q[cid]) begin
      status_d = STATUS_UNDEF;
    end else if (total != {1'b0, desc_rd_q.dims}) begin
      status_d = STATUS_MISMATCH;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && head_i.kind == CMD_IDX) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ACC;
      ST_ACC: begin
        if (!cur_q.item.last_index) begin
          state_d = ST_IDLE;
        end else if (status_d == STATUS_OK) begin
          state_d = ST_ADR_LO;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ADR_LO: state_d = ST_ADR_HI;
      ST_ADR_HI: state_d = ST_DONE;
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o    = 1'b0;
    hdr_we   = 1'b0;
    bnd_we   = 1'b0;
    rd_en    = 1'b0;
    hi_sel   = 1'b0;
    size_sel = 1'b0;
    plo_en   = 1'b0;
    phi_en   = 1'b0;
    acc_step = 1'b0;
    load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o  = !empty_i;
        hdr_we = !empty_i && head_i.kind == CMD_HDR;
        bnd_we = !empty_i && head_i.kind == CMD_BND;
        rd_en  = !empty_i && head_i.kind == CMD_IDX;
      end
      ST_MUL_LO: plo_en = 1'b1;
      ST_MUL_HI: begin
        hi_sel = 1'b1;
        phi_en = 1'b1;
      end
      ST_ACC: acc_step = 1'b1;
      ST_ADR_LO: begin
        size_sel = 1'b1;
        plo_en   = 1'b1;
      end
      ST_ADR_HI: begin
        size_sel = 1'b1;
        hi_sel   = 1'b1;
        phi_en   = 1'b1;
      end
      ST_DONE: load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Descriptor memory
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      desc_mem[hid] <= '{base: head_i.item.base_addr, size: head_i.item.elem_size,
                         dims: head_i.item.num_dims};
    end
    if (rd_en) begin
      desc_rd_q <= desc_mem[hid];
    end
  end

  // Bounds memory
  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      bnd_mem[wr_slot] <= '{lower: head_i.item.lower_bound, upper: head_i.item.upper_bound};
    end
    if (rd_en) begin
      bnd_rd_q <= bnd_mem[rd_slot];
    end
  end

  // Mark defined arrays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      defined_q <= '0;
    end else if (hdr_we) begin
      defined_q[hid] <= 1'b1;
    end
  end

  // Capture the index item and latch partial products
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      cur_q   <= head_i;
      apply_q <= apply;
    end
    if (plo_en) begin
      p_lo_q <= prod;
    end
    if (phi_en) begin
      p_hi_q <= prod[31:0];
    end
    if (acc_step) begin
      status_q <= status_d;
    end
  end

  // Accumulate the offset and count subscripts; clear when the result leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (load) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (acc_step) begin
      if (apply_q) begin
        acc_q <= acc_d;
      end
      if (!cur_q.item.last_index && cnt_q != CNT_SAT) begin
        cnt_q <= cnt_q + 4'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.address      <= (status_q == STATUS_OK) ? addr_sum : '0;
      out_q.result_array <= cur_q.item.array_id;
      out_q.status       <= status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/maag_checker.sv
// ----------------------------------------------------------------------------
// Multidim array address generator: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "multidim_array_address_generator_defines.svh"

module maag_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input maag_pkg::out_item_t out_item_o
);
  import maag_pkg::*;

  // Hold a stalled result beat
  `MAAG_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "result beat dropped or changed while stalled")

  // Report no address for a failed access
  `MAAG_ASSERT(a_err_addr, out_valid_o && out_item_o.status != STATUS_OK |-> out_item_o.address == 0, "error result carries an address")

  // Drop any result during reset
  `MAAG_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "result valid during reset")

  // Accept input straight after reset
  `MAAG_ASSERT_RST(a_rst_ready, $rose(rst_ni) |-> in_ready_o, "not ready after reset")

endmodule

bind multidim_array_address_generator maag_checker u_maag_checker (.*);

>>> test/tb_multidim_array_address_generator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multidim array address generator testbench
// Drives descriptor, bounds and subscript beats through the valid/ready input,
// predicts each row-major address with an in-bench model of the descriptor
// table, and checks every result beat field by field under varied back-pressure.
// ----------------------------------------------------------------------------
module tb_multidim_array_address_generator;
  import maag_pkg::*;

  localparam int NUM_ARRAYS     = 16;
  localparam int MAX_DIMS       = 10;
  localparam int RANDOM_BEATS   = 400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 20;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Shadow descriptor table and access state
  logic [31:0] desc_base    [NUM_ARRAYS];
  logic [15:0] desc_size    [NUM_ARRAYS];
  logic [3:0]  desc_dims    [NUM_ARRAYS];
  bit          desc_defined [NUM_ARRAYS];
  logic [15:0] bound_lo     [NUM_ARRAYS*MAX_DIMS];
  logic [15:0] bound_hi     [NUM_ARRAYS*MAX_DIMS];
  bit          bound_set    [NUM_ARRAYS*MAX_DIMS];
  logic [63:0] run_offset   = '0;
  logic [3:0]  subscript_cnt = '0;

  out_item_t expected_addr_q[$];
  stim_row_t directed_rows[$];
  int        errors        = 0;
  int        counted_beats = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        hold_requests = 0;
  int        hold_served   = 0;
  int        hold_left     = 0;
  int        quiet_cycles  = 0;

  multidim_array_address_generator #(
    .NUM_ARRAYS (NUM_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the shadow state by one accepted beat; flag a result if one is due
  function automatic void predict_address(input in_item_t it, output bit has_res,
                                          output out_item_t res);
    logic [3:0]  id;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] sub;
    int          slot;
    has_res = 1'b0;
    res     = '0;
    id      = it.array_id;
    case (func_e'(it.func))
      FUNC_HDR: begin
        desc_base[id]    = it.base_addr;
        desc_size[id]    = it.elem_size;
        desc_dims[id]    = (it.num_dims > MAX_DIMS) ? 4'(MAX_DIMS) : it.num_dims;
        desc_defined[id] = 1'b1;
      end
      FUNC_BND: begin
        if (it.dim_pos >= 1 && it.dim_pos <= MAX_DIMS) begin
          slot = id * MAX_DIMS + it.dim_pos - 1;
          bound_lo[slot]  = it.lower_bound;
          bound_hi[slot]  = it.upper_bound;
          bound_set[slot] = 1'b1;
        end
      end
      FUNC_IDX: begin
        // Subscripts past the table only count
        if (subscript_cnt < MAX_DIMS) begin
          slot = id * MAX_DIMS + subscript_cnt;
          lo   = {{48{bound_lo[slot][15]}}, bound_lo[slot]};
          hi   = {{48{bound_hi[slot][15]}}, bound_hi[slot]};
          sub  = {{48{it.index_value[15]}}, it.index_value};
          run_offset = run_offset * (hi - lo + 64'd1) + (sub - lo);
        end
        if (!it.last_index) begin
          if (subscript_cnt != CNT_SAT) subscript_cnt++;
        end else begin
          has_res          = 1'b1;
          res.result_array = id;
          if (!desc_defined[id]) begin
            res.status = STATUS_UNDEF;
          end else if (int'(subscript_cnt) + 1 != int'(desc_dims[id])) begin
            res.status = STATUS_MISMATCH;
          end else begin
            res.status  = STATUS_OK;
            res.address = {32'b0, desc_base[id]} + run_offset * {48'b0, desc_size[id]};
          end
          run_offset    = '0;
          subscript_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Random filler for the fields a beat does not use
  function automatic in_item_t junk_item();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t hdr_beat(input logic [3:0] id, input logic [31:0] base,
                                        input logic [15:0] size, input logic [3:0] nd);
    in_item_t it;
    it           = junk_item();
    it.func      = FUNC_HDR;
    it.array_id  = id;
    it.base_addr = base;
    it.elem_size = size;
    it.num_dims  = nd;
    return it;
  endfunction

  function automatic in_item_t bnd_beat(input logic [3:0] id, input logic [3:0] pos,
                                        input logic [15:0] lo, input logic [15:0] hi);
    in_item_t it;
    it             = junk_item();
    it.func        = FUNC_BND;
    it.array_id    = id;
    it.dim_pos     = pos;
    it.lower_bound = lo;
    it.upper_bound = hi;
    return it;
  endfunction

  function automatic in_item_t idx_beat(input logic [3:0] id, input logic [15:0] v,
                                        input logic last);
    in_item_t it;
    it             = junk_item();
    it.func        = FUNC_IDX;
    it.array_id    = id;
    it.index_value = v;
    it.last_index  = last;
    return it;
  endfunction

  function automatic void add_row(input in_item_t it);
    stim_row_t r;
    r       = '0;
    r.item  = it;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_checked_row(input in_item_t it, input logic [63:0] addr,
                                          input logic [3:0] id, input status_e st);
    stim_row_t r;
    r                   = '0;
    r.item              = it;
    r.typed             = 1'b1;
    r.want.address      = addr;
    r.want.result_array = id;
    r.want.status       = st;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // Offer one beat, hold it until accepted, then update the prediction
  task automatic drive_beat(input in_item_t it, input bit typed, input out_item_t want);
    bit        produced;
    out_item_t predicted;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_address(it, produced, predicted);
    if (produced) expected_addr_q.insert(expected_addr_q.size(), typed ? want : predicted);
    if (!(it.func == FUNC_NONE ||
          (it.func == FUNC_BND && (it.dim_pos == 0 || it.dim_pos > MAX_DIMS))))
      counted_beats++;
  endtask

  // Mostly narrow ranges, sometimes full-width or reversed
  task automatic rand_bounds(output logic [15:0] lo, output logic [15:0] hi);
    int r;
    r  = $urandom_range(99);
    lo = 16'($urandom);
    if (r < 70)      hi = lo + 16'($urandom_range(0, 5));
    else if (r < 85) hi = 16'($urandom);
    else             hi = lo - 16'($urandom_range(1, 4));
  endtask

  // Write the bound that the next subscript of this array will read, if missing
  task automatic cover_slot(input logic [3:0] id);
    logic [15:0] lo;
    logic [15:0] hi;
    if (subscript_cnt < MAX_DIMS && !bound_set[id * MAX_DIMS + subscript_cnt]) begin
      rand_bounds(lo, hi);
      drive_beat(bnd_beat(id, subscript_cnt + 4'd1, lo, hi), 1'b0, '0);
    end
  endtask

  task automatic noise_beat();
    in_item_t it;
    int       r;
    it = junk_item();
    r  = $urandom_range(2);
    if (r == 0) begin
      it.func = FUNC_NONE;
    end else if (r == 1) begin
      it.func    = FUNC_BND;
      it.dim_pos = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(MAX_DIMS + 1, 15));
    end else begin
      it.func = FUNC_HDR;
    end
    drive_beat(it, 1'b0, '0);
  endtask

  task automatic define_array();
    logic [3:0]  id;
    logic [3:0]  nd;
    logic [15:0] size;
    logic [15:0] lo;
    logic [15:0] hi;
    int          r;
    id = 4'($urandom_range(NUM_ARRAYS - 1));
    r  = $urandom_range(99);
    if (r < 60)      nd = 4'($urandom_range(1, 3));
    else if (r < 80) nd = 4'($urandom_range(4, MAX_DIMS));
    else if (r < 90) nd = 4'd0;
    else             nd = 4'($urandom_range(MAX_DIMS + 1, 15));
    size = ($urandom_range(99) < 5) ? 16'd0 : 16'($urandom_range(1, 65535));
    drive_beat(hdr_beat(id, $urandom, size, nd), 1'b0, '0);
    for (int p = 1; p <= nd && p <= MAX_DIMS; p++) begin
      rand_bounds(lo, hi);
      drive_beat(bnd_beat(id, 4'(p), lo, hi), 1'b0, '0);
    end
  endtask

  // One access: mostly well-formed, sometimes short, long, mixed or unterminated
  task automatic run_access();
    logic [3:0]  id;
    logic [3:0]  item_id;
    logic [15:0] v;
    logic        last;
    int          n;
    int          r;
    id = 4'($urandom_range(NUM_ARRAYS - 1));
    for (int t = 0; t < 8 && !desc_defined[id]; t++) id = 4'($urandom_range(NUM_ARRAYS - 1));
    n = desc_defined[id] ? int'(desc_dims[id]) : $urandom_range(1, 3);
    r = $urandom_range(99);
    if (r < 8)                n = n + 1;
    else if (r < 16 && n > 1) n = n - 1;
    else if (r < 20)          n = $urandom_range(MAX_DIMS + 1, 17);
    if (n == 0) n = $urandom_range(1, 2);
    for (int k = 0; k < n; k++) begin
      item_id = ($urandom_range(99) < 8) ? 4'($urandom_range(NUM_ARRAYS - 1)) : id;
      if ($urandom_range(99) < 4) noise_beat();
      cover_slot(item_id);
      if (subscript_cnt < MAX_DIMS && $urandom_range(4) != 0)
        v = bound_lo[item_id * MAX_DIMS + subscript_cnt] + 16'($urandom_range(0, 3));
      else
        v = 16'($urandom);
      last = (k == n - 1) && ($urandom_range(99) >= 4);
      drive_beat(idx_beat(item_id, v, last), 1'b0, '0);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_addr_q.size() == 0) begin
      $display("%0t: unexpected result: address %h array %0d status %0d",
               $time, got.address, got.result_array, got.status);
      errors++;
      return;
    end
    want = expected_addr_q.pop_front();
    if (got.address !== want.address) begin
      $display("%0t: address mismatch: expected %h actual %h", $time, want.address,
               got.address);
      errors++;
    end
    if (got.result_array !== want.result_array) begin
      $display("%0t: result_array mismatch: expected %0d actual %0d", $time,
               want.result_array, got.result_array);
      errors++;
    end
    if (got.status !== want.status) begin
      $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
               got.status);
      errors++;
    end
  endtask

  // Result side: check accepted beats, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_item_o);
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: give up after a long run of cycles with no beat on either side
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int start_beats;
    int r;
    bit pressed;
    // Assert reset with an edge so the asynchronous reset takes effect at once
    rst_ni  <= 1'b0;
    pressed = 1'b0;
    for (int i = 0; i < NUM_ARRAYS; i++) desc_defined[i] = 1'b0;
    for (int i = 0; i < NUM_ARRAYS * MAX_DIMS; i++) bound_set[i] = 1'b0;

    // Directed rows: error codes, extremes, ignored beats, mid-access headers
    add_row(bnd_beat(4'd3, 4'd1, -16'sd5, 16'sd5));
    add_checked_row(idx_beat(4'd3, 16'd0, 1'b1), 64'd0, 4'd3, STATUS_UNDEF);
    add_row(hdr_beat(4'd0, 32'hFFFF_FFFF, 16'hFFFF, 4'd1));
    add_row(bnd_beat(4'd0, 4'd1, 16'h8000, 16'h7FFF));
    add_checked_row(idx_beat(4'd0, 16'h7FFF, 1'b1), 64'h1_FFFE_0000, 4'd0, STATUS_OK);
    add_checked_row(idx_beat(4'd0, 16'h8000, 1'b1), 64'hFFFF_FFFF, 4'd0, STATUS_OK);
    add_row(hdr_beat(4'd1, 32'h1000, 16'd4, 4'd2));
    add_row(bnd_beat(4'd1, 4'd2, 16'sd0, 16'sd9));
    add_row(bnd_beat(4'd1, 4'd1, 16'sd1, 16'sd3));
    add_row(bnd_beat(4'd1, 4'd0, 16'sd7, 16'sd7));
    add_row(bnd_beat(4'd1, 4'd15, 16'sd7, 16'sd7));
    add_row(idx_beat(4'd1, 16'sd3, 1'b0));
    add_row(hdr_beat(4'd5, 32'h0, 16'd1, 4'd0));
    add_row(idx_beat(4'd1, 16'sd0, 1'b1) | {FUNC_NONE, {($bits(in_item_t)-2){1'b0}}});
    add_checked_row(idx_beat(4'd1, 16'sd9, 1'b1), 64'h1074, 4'd1, STATUS_OK);
    add_checked_row(idx_beat(4'd1, 16'sd2, 1'b1), 64'd0, 4'd1, STATUS_MISMATCH);
    add_row(bnd_beat(4'd5, 4'd1, 16'sd0, 16'sd0));
    add_checked_row(idx_beat(4'd5, 16'sd0, 1'b1), 64'd0, 4'd5, STATUS_MISMATCH);
    add_row(hdr_beat(4'd6, 32'h8000_0000, 16'd2, 4'd15));
    add_row(bnd_beat(4'd6, 4'd1, -16'sd1, -16'sd1));
    add_checked_row(idx_beat(4'd6, -16'sd1, 1'b1), 64'd0, 4'd6, STATUS_MISMATCH);
    add_row(idx_beat(4'd0, 16'sd5, 1'b0));
    add_row(idx_beat(4'd1, 16'sd4, 1'b1));

    // Hold reset, then release it once
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      drive_beat(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Random sequences, idling phases of a hundred beats each
    start_beats = counted_beats;
    while (counted_beats - start_beats < RANDOM_BEATS) begin
      case ((counted_beats - start_beats) / 100)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 63; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 9;  stall_pct = 9;  end
      endcase
      // Stall the result side for a long stretch while beats keep coming
      if (!pressed && counted_beats - start_beats >= 50) begin
        pressed = 1'b1;
        hold_requests++;
      end
      r = $urandom_range(99);
      if (r < 30)      define_array();
      else if (r < 90) run_access();
      else             noise_beat();
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then allow for any stray beat
    while (expected_addr_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/maag_pkg.sv
sv/maag_front.sv
sv/maag_queue.sv
sv/maag_back.sv
sv/multidim_array_address_generator.sv
sv/maag_checker.sv
test/tb_multidim_array_address_generator.sv
